// ===== hw/rtl/oss_pkg.sv =====
// Shared types and constants for the online stock span block.
// Used by oss_front, oss_stack, online_stock_span, the span checker and the testbench. No dependencies.
`default_nettype none
package oss_pkg;

  // Stack depth must be a power of two: the stack is a ring over the memory.
  localparam int STACK_DEPTH = 1024;
  localparam int SPAN_BITS   = 20;
  localparam int PRICE_W     = 31;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(STACK_DEPTH);

  // Item handed from the front queue to the stack engine.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
  } oss_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oss_front.sv =====
// Front end: accepts price transactions into a short queue.
// Depends on oss_pkg. Feeds oss_stack through an oss_req_t and a pop strobe.
`default_nettype none
module oss_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [oss_pkg::PRICE_W-1:0] in_price,
  output oss_pkg::oss_req_t           req,
  input  wire logic                   req_pop
);
  import oss_pkg::*;

  logic [PRICE_W-1:0] q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  q_cnt_r;
  logic               push, pop;

  // Queue handshake
  assign in_stall = (q_cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = req_pop && (q_cnt_r != '0);

  assign req.valid = (q_cnt_r != '0);
  assign req.price = q_mem_r[rd_ptr_r];

  // Queue storage, no reset needed on payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_price;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      q_cnt_r <= QCNT_W'(q_cnt_r + QCNT_W'(push) - QCNT_W'(pop));
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QUEUE_DEPTH)) else $error("front queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !push) else $error("push into full queue");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> q_cnt_r == QCNT_W'($past(q_cnt_r) - 1'b1))
    else $error("pop did not drain queue");

endmodule
`default_nettype wire

// ===== hw/rtl/oss_stack.sv =====
// Back end: monotonic price/span stack in a ring memory, one result per item.
// Depends on oss_pkg. Takes items from oss_front, drives the result register.
`default_nettype none
module oss_stack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  oss_pkg::oss_req_t                  req,
  output logic                               req_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [oss_pkg::SPAN_BITS-1:0]      out_span,
  output logic                               out_truncated
);
  import oss_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_RD} state_t;

  localparam int WORD_W = PRICE_W + SPAN_BITS;

  // Stack memory: {price, span}
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;

  state_t               state_r, state_nxt;
  logic [PRICE_W-1:0]   price_r, price_nxt;
  logic [SPAN_BITS-1:0] span_r, span_nxt;
  logic [PRICE_W-1:0]   top_price_r, top_price_nxt;
  logic [SPAN_BITS-1:0] top_span_r, top_span_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PTR_W-1:0]     base_r, base_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SPAN_BITS-1:0] out_span_r, out_span_nxt;
  logic                 out_trunc_r, out_trunc_nxt;

  logic                 top_le, can_out;
  logic [SPAN_BITS:0]   sum;
  logic [SPAN_BITS-1:0] span_add;

  assign top_le  = (cnt_r != '0) && (top_price_r <= price_r);
  assign sum     = {1'b0, span_r} + {1'b0, top_span_r};
  assign span_add = sum[SPAN_BITS] ? SPAN_MAX : sum[SPAN_BITS-1:0];
  assign can_out = !out_valid_r || !out_stall;

  // New entry goes just above the top; when full this lands on the oldest entry
  assign wr_addr = PTR_W'(base_r + cnt_r[PTR_W-1:0]);
  // Entry below the current top
  assign rd_addr = PTR_W'(base_r + PTR_W'(cnt_r - CNT_W'(2)));

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    price_nxt     = price_r;
    span_nxt      = span_r;
    top_price_nxt = top_price_r;
    top_span_nxt  = top_span_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_span_nxt  = out_span_r;
    out_trunc_nxt = out_trunc_r;
    req_pop       = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req.valid) begin
          req_pop   = 1'b1;
          price_nxt = req.price;
          span_nxt  = SPAN_BITS'(1);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (top_le) begin
          // pop the top, fold its span in
          span_nxt = span_add;
          cnt_nxt  = CNT_W'(cnt_r - 1'b1);
          if (cnt_r > CNT_W'(1)) begin
            rd_en     = 1'b1;
            state_nxt = ST_RD;
          end
        end else if (can_out) begin
          // push, dropping the oldest entry when full
          wr_en         = 1'b1;
          top_price_nxt = price_r;
          top_span_nxt  = span_r;
          if (cnt_r == CNT_FULL) begin
            base_nxt    = PTR_W'(base_r + 1'b1);
            dropped_nxt = 1'b1;
          end else begin
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end
          out_valid_nxt = 1'b1;
          out_span_nxt  = span_r;
          out_trunc_nxt = dropped_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD: begin
        top_price_nxt = rd_data_r[WORD_W-1:SPAN_BITS];
        top_span_nxt  = rd_data_r[SPAN_BITS-1:0];
        state_nxt     = ST_CMP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Stack memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {price_r, span_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    price_r     <= price_nxt;
    span_r      <= span_nxt;
    top_price_r <= top_price_nxt;
    top_span_r  <= top_span_nxt;
    out_span_r  <= out_span_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_span      = out_span_r;
  assign out_truncated = out_trunc_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("stack count past depth");
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |=> dropped_r) else $error("truncated flag cleared");
  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_span_r != '0) else $error("zero span");
  a_base_moves_full: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r != base_nxt) |-> (cnt_r == CNT_FULL && wr_en))
    else $error("base moved without a full push");
  a_no_mem_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en)) else $error("memory read and write together");

endmodule
`default_nettype wire

// ===== hw/rtl/online_stock_span.sv =====
// Online stock span: one span per price transaction.
// Path: an accepted price goes through the front queue, then the stack engine's idle
//   and compare states, into the result register; each stack pop adds a read state
//   and another compare (only a compare for a pop that empties the stack).
// The engine takes one item at a time; entries are pushed once, popped at most once.
// Reset: synchronous active-low rst_n empties queue and stack, clears the sticky truncated flag.
// Depends on oss_pkg, oss_front, oss_stack.
`default_nettype none
module online_stock_span (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [oss_pkg::PRICE_W-1:0]   in_price,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [oss_pkg::SPAN_BITS-1:0]      out_span,
  output logic                               out_truncated
);
  import oss_pkg::*;

  oss_req_t req;
  logic     req_pop;

  // Front: input queue
  oss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_price (in_price),
    .req      (req),
    .req_pop  (req_pop)
  );

  // Back: stack engine and result register
  oss_stack u_stack (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .req_pop       (req_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_span      (out_span),
    .out_truncated (out_truncated)
  );

endmodule
`default_nettype wire

// ===== verif/oss_span_checker.sv =====
// Span checker: mirrors the price stack, predicts one span per price transaction
// and compares each returned span against the oldest prediction.
// Depends on oss_pkg; instantiated next to online_stock_span by the testbench top.
module oss_span_checker
  import oss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [PRICE_W-1:0] in_price,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [SPAN_BITS-1:0] out_span,
  input  wire logic               out_truncated,
  output int unsigned             fail_count,
  output int unsigned             spans_pending,
  output int unsigned             spans_checked,
  output int unsigned             widest_span,
  output logic                    saw_truncated
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SPAN_BITS-1:0] span;
    logic                 truncated;
  } span_result_t;

  // Predictor state: a monotonic stack, oldest entry at index 0.
  logic [PRICE_W-1:0]   stack_price[$];
  logic [SPAN_BITS-1:0] stack_span[$];
  logic                 history_dropped = 1'b0;

  // Spans predicted but not yet returned, oldest first.
  span_result_t span_expect_q[$];

  int unsigned fails   = 0;
  int unsigned checked = 0;
  int unsigned widest  = 0;

  always @(posedge clk) begin : track
    logic [SPAN_BITS:0] run_sum;
    span_result_t       want;
    if (!rst_n) begin
      stack_price.delete();
      stack_span.delete();
      span_expect_q.delete();
      history_dropped = 1'b0;
    end else begin
      // Accepted price: pop every entry priced at or below it, summing spans.
      if (in_valid && !in_stall) begin
        run_sum = 1;
        while (stack_price.size() > 0 && stack_price[$] <= in_price) begin
          run_sum = run_sum + stack_span[$];
          if (run_sum > SPAN_MAX) run_sum = SPAN_MAX;
          void'(stack_price.pop_back());
          void'(stack_span.pop_back());
        end
        // Full stack: the oldest entry falls off the bottom, flag sticks.
        if (stack_price.size() >= STACK_DEPTH) begin
          void'(stack_price.pop_front());
          void'(stack_span.pop_front());
          history_dropped = 1'b1;
        end
        stack_price.push_back(in_price);
        stack_span.push_back(run_sum[SPAN_BITS-1:0]);
        span_expect_q.push_back('{span: run_sum[SPAN_BITS-1:0],
                                  truncated: history_dropped});
      end

      // Returned span: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (span_expect_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected span %0d truncated %0b", $realtime, out_span,
                     out_truncated);
          fails++;
        end else begin
          want = span_expect_q.pop_front();
          if (out_span !== want.span || out_truncated !== want.truncated) begin
            if (fails < 10)
              $display("%0t: span mismatch: expected span %0d truncated %0b, got span %0d truncated %0b",
                       $realtime, want.span, want.truncated, out_span, out_truncated);
            fails++;
          end
          checked++;
          if (out_span > widest) widest = out_span;
        end
      end
    end

    // Exported copies, updated once per edge.
    fail_count    <= fails;
    spans_pending <= span_expect_q.size();
    spans_checked <= checked;
    widest_span   <= widest;
    saw_truncated <= history_dropped;
  end

endmodule

// ===== verif/online_stock_span_tb.sv =====
// Testbench top for online_stock_span: clock, reset, price stimulus with bursty
// input and stalling output, verdict. Depends on oss_pkg, online_stock_span and oss_span_checker.
module online_stock_span_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oss_pkg::*;

  localparam logic [PRICE_W-1:0] PRICE_TOP  = '1;
  localparam int                 PLAN_ITEMS = 1250;
  localparam int                 RAMP_START = 150;

  typedef enum int {SEG_UNIFORM, SEG_NARROW, SEG_RISING, SEG_FALLING, SEG_FLAT} price_shape_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PRICE_W-1:0]   in_price;
  logic                 out_valid;
  logic                 out_stall;
  logic [SPAN_BITS-1:0] out_span;
  logic                 out_truncated;

  int unsigned fail_count;
  int unsigned spans_pending;
  int unsigned spans_checked;
  int unsigned widest_span;
  logic        saw_truncated;

  logic [PRICE_W-1:0] price_plan[$];
  int unsigned        prices_sent = 0;

  online_stock_span u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_price      (in_price),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_span      (out_span),
    .out_truncated (out_truncated)
  );

  oss_span_checker u_span_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_price      (in_price),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_span      (out_span),
    .out_truncated (out_truncated),
    .fail_count    (fail_count),
    .spans_pending (spans_pending),
    .spans_checked (spans_checked),
    .widest_span   (widest_span),
    .saw_truncated (saw_truncated)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Price sender: builds the plan, releases reset, drives bursts, gives the verdict.
  initial begin : price_driver
    int           burst_left;
    int           gap;
    int           seg_len;
    logic [31:0]  walk;
    logic [31:0]  anchor;
    logic         ramp_done;
    price_shape_t shape;

    in_valid <= 1'b0;
    in_price <= '0;
    rst_n    <= 1'b0;
    ramp_done = 1'b0;

    // Directed prices: extremes, ties, alternating bits, a short descent and rebound.
    price_plan = '{31'd0, 31'd0, PRICE_TOP, PRICE_TOP, 31'h5555_5555, 31'h2AAA_AAAA,
                   31'd5, 31'd4, 31'd3, 31'd2, 31'd1, 31'd3, PRICE_TOP - 31'd1,
                   31'd1, 31'd1, PRICE_TOP, 31'h4000_0000, 31'h3FFF_FFFF};

    // Shaped random runs, with one long strictly falling run in the middle.
    while (price_plan.size() < PLAN_ITEMS) begin
      if (!ramp_done && price_plan.size() >= RAMP_START) begin
        // Top price clears the stack, then the fall outgrows it and drops history.
        walk = {1'b0, PRICE_TOP};
        price_plan.push_back(PRICE_TOP);
        repeat (STACK_DEPTH + 6) begin
          walk = walk - $urandom_range(1, 1024);
          price_plan.push_back(walk[PRICE_W-1:0]);
        end
        ramp_done = 1'b1;
      end else begin
        shape   = price_shape_t'($urandom_range(SEG_UNIFORM, SEG_FLAT));
        seg_len = $urandom_range(4, 40);
        walk    = $urandom() & 32'h7FFF_FFFF;
        anchor  = walk & 32'h7FFF_FFF0;
        repeat (seg_len) begin
          case (shape)
            SEG_UNIFORM: walk = $urandom() & 32'h7FFF_FFFF;
            SEG_NARROW:  walk = anchor + $urandom_range(0, 15);
            SEG_RISING: begin
              walk = walk + $urandom_range(0, 3);
              if (walk > 32'h7FFF_FFFF) walk = 32'h7FFF_FFFF;
            end
            SEG_FALLING: begin
              if (walk < 4) walk = 0;
              else walk = walk - $urandom_range(0, 3);
            end
            default: ;
          endcase
          price_plan.push_back(walk[PRICE_W-1:0]);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = $urandom_range(1, 24);
    foreach (price_plan[i]) begin
      // End of burst: idle for a random gap, sometimes none.
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 24);
      end
      in_valid <= 1'b1;
      in_price <= price_plan[i];
      do @(posedge clk); while (in_stall);
      prices_sent++;
      burst_left--;
    end
    in_valid <= 1'b0;

    // Drain, then leave room for any stray result. The pending count is a registered copy, so it lags.
    do @(posedge clk); while (spans_pending != 0);
    repeat (40) @(posedge clk);

    $display("Sent %0d prices: directed extremes and ties, shaped random runs,", prices_sent);
    $display("one falling run past the %0d-entry stack; %0d spans checked,",
             STACK_DEPTH, spans_checked);
    $display("widest %0d, truncated seen %0b.", widest_span, saw_truncated);
    if (spans_pending != 0)
      $display("%0d predicted spans never returned", spans_pending);
    if (fail_count == 0 && spans_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result receiver: stall patterns of its own, plus one long hold-off mid-run.
  initial begin : span_receiver
    int   mode;
    int   len;
    int   tick;
    logic held_off;

    out_stall <= 1'b0;
    held_off = 1'b0;
    tick     = 0;
    wait (rst_n);
    forever begin
      if (!held_off && prices_sent >= 300) begin
        // Long hold-off: the sender keeps offering, so the block backs up.
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 80);
        repeat (len) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 40);
            default: out_stall <= ((tick % 5) < 2);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("timeout: run did not complete");
    $display("TEST FAILED");
    $finish;
  end

endmodule
